/* sv/lrs_pkg.sv */
package lrs_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  localparam int unsigned RTT_W   = 24;
  localparam int unsigned FIELD_W = 24;
  localparam int unsigned SEEN_W  = 32;
  localparam int unsigned M2_W    = 64;

  localparam logic [30:0] LN2_Q31   = 31'd1488522236;
  localparam logic [36:0] LN1E9_Q32 = 37'd89005749036;
  localparam int unsigned LOG2_FRAC = 28;

  // One classified sample handed from the front end to the math engine.
  typedef struct packed {
    logic              valid_sample;
    logic [RTT_W-1:0]  rtt;
  } lrs_cmd_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] mu;
    logic [FIELD_W-1:0]        sigma;
    logic [SEEN_W-1:0]         seen;
    logic                      pub;
  } lrs_res_t;

endpackage

/* sv/log_rtt_running_stats.sv */
// Channel   Dir  tdata fields (low bit up)              tuser
// s_axis    in   rtt_ns[23:0]                          -
// m_axis    out  mu_log[23:0] sigma_log[47:24]         published
//                samples_seen[79:48]
// A nonzero sample runs 28 squaring steps for the log, a 64-step mean
// divider, a 64-step variance divider and a 32-step square root; the
// first sample skips the variance, and a zero sample goes straight to
// the output. The math engine handles one
// item at a time. A two-entry queue keeps taking items until it is full
// while it works, and a held result stalls only the engine. Reset is asynchronous, active low.
module log_rtt_running_stats #(
  parameter int unsigned COUNT_WIDTH = lrs_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = lrs_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // rtt_ns
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // mu_log, sigma_log, samples_seen
  output logic        m_axis_tuser    // published
);
  import lrs_pkg::*;

  lrs_cmd_t cmd;
  lrs_res_t res;
  logic     qv, qr;

  lrs_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready), .s_rtt_i(s_axis_tdata),
    .q_cmd_o(cmd), .q_valid_o(qv), .q_ready_i(qr)
  );

  lrs_back #(.COUNT_WIDTH(COUNT_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_cmd_i(cmd), .q_valid_i(qv), .q_ready_o(qr),
    .res_o(res), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {res.seen, res.sigma, res.mu};
  assign m_axis_tuser = res.pub;
endmodule

/* sv/lrs_front.sv */
module lrs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [23:0]      s_rtt_i,
  output lrs_pkg::lrs_cmd_t q_cmd_o,
  output logic             q_valid_o,
  input  logic             q_ready_i
);
  import lrs_pkg::*;

  // Two-entry queue between intake and the math engine.
  lrs_cmd_t  mem_q [2];
  logic      wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic      push, pop;

  assign s_tready_o = (cnt_q != 2'd2);
  assign push       = s_tvalid_i && s_tready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_cmd_o    = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ pop;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].valid_sample <= (s_rtt_i != '0);
      mem_q[wp_q].rtt          <= s_rtt_i;
    end
  end
endmodule

/* sv/lrs_back.sv */
module lrs_back #(
  parameter int unsigned COUNT_WIDTH = lrs_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = lrs_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lrs_pkg::lrs_cmd_t q_cmd_i,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  output lrs_pkg::lrs_res_t res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);
  import lrs_pkg::*;

  localparam int unsigned SH = 32 - FRAC_BITS;
  localparam int unsigned DW = COUNT_WIDTH + 2;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_NORM = 12'b000000000010,
    ST_SQR  = 12'b000000000100,
    ST_LNMU = 12'b000000001000,
    ST_LNFN = 12'b000000010000,
    ST_MEAN = 12'b000000100000,
    ST_DIV  = 12'b000001000000,
    ST_MUP  = 12'b000010000000,
    ST_PROD = 12'b000100000000,
    ST_VDIV = 12'b001000000000,
    ST_SQRT = 12'b010000000000,
    ST_OUT  = 12'b100000000000
  } st_e;

  st_e st_q;

  logic [COUNT_WIDTH-1:0] count_q;
  logic signed [23:0]     mean_q;
  logic [63:0]            m2_q;
  logic signed [23:0]     emu_q;
  logic [23:0]            esig_q;
  logic                   pub_q;

  logic [23:0] t_q;
  logic [4:0]  e_q;
  logic [31:0] m_q;
  logic [27:0] l_q;
  logic [5:0]  step_q;
  logic [63:0] sq;
  logic signed [23:0] y_q;
  logic [63:0] p_q;

  // Shared restoring divider: 64-bit dividend over a count-sized divisor.
  logic [63:0]            dvd_q;
  logic [DW-2:0]          rem_q;
  logic [COUNT_WIDTH-1:0] dvs_q;
  logic                   dneg_q;
  logic [DW-1:0]          rtry;
  logic [DW-1:0]          rsh;

  logic [63:0] sv_q, sr_q, sbit_q;
  logic signed [24:0] delta_q;

  logic res_full_q;

  assign q_ready_o   = (st_q == ST_IDLE) && !res_full_q;
  assign res_valid_o = res_full_q;
  assign sq          = {32'd0, m_q} * {32'd0, m_q};
  assign rsh         = {rem_q, dvd_q[63]};
  assign rtry        = rsh - {2'b00, dvs_q};

  function automatic logic [4:0] msb24(input logic [23:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 24; i++) if (v[i]) r = 5'(i);
    return r;
  endfunction

  logic [COUNT_WIDTH-1:0] cmax;
  assign cmax = '1;

  logic [37:0] mag;
  logic [37:0] magr;
  logic signed [49:0] prodw;

  always_comb begin
    mag   = {1'b0, LN1E9_Q32} - {1'b0, p_q[36:0]};
    magr  = (mag + (38'd1 << (SH - 1))) >> SH;
    prodw = 50'(delta_q) * 50'(25'(y_q) - 25'(mean_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      count_q    <= '0;
      mean_q     <= '0;
      m2_q       <= '0;
      emu_q      <= ((FRAC_BITS + 2) >= 23) ? 24'sh800000 : 24'(-(64'sd4 <<< FRAC_BITS));
      esig_q     <= 24'(64'd1 << (FRAC_BITS - 1));
      pub_q      <= 1'b0;
      res_full_q <= 1'b0;
      step_q     <= '0;
    end else begin
      if (res_full_q && res_ready_i) res_full_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (q_valid_i && !res_full_q) begin
            t_q   <= q_cmd_i.rtt;
            pub_q <= 1'b0;
            st_q  <= q_cmd_i.valid_sample ? ST_NORM : ST_OUT;
          end
        end
        ST_NORM: begin
          e_q    <= msb24(t_q);
          m_q    <= 32'({8'd0, t_q} << (5'd31 - msb24(t_q)));
          l_q    <= '0;
          step_q <= '0;
          st_q   <= ST_SQR;
        end
        ST_SQR: begin
          l_q <= {l_q[26:0], sq[63]};
          m_q <= sq[63] ? sq[63:32] : sq[62:31];
          step_q <= step_q + 6'd1;
          if (step_q == 6'(LOG2_FRAC - 1)) st_q <= ST_LNMU;
        end
        ST_LNMU: begin
          p_q  <= (({e_q, l_q} * {33'd0, LN2_Q31}) + 64'(1 << 26)) >> 27;
          st_q <= ST_LNFN;
        end
        ST_LNFN: begin
          y_q  <= (magr > 38'(1 << 23)) ? 24'sh800000 : 24'(-$signed(magr));
          if (count_q != cmax) count_q <= count_q + 1'b1;
          st_q <= ST_MEAN;
        end
        ST_MEAN: begin
          delta_q <= 25'(y_q) - 25'(mean_q);
          st_q    <= ST_DIV;
          step_q  <= '0;
          dneg_q  <= y_q < mean_q;
          dvd_q   <= {39'd0, (y_q < mean_q) ? 25'(25'(mean_q) - 25'(y_q))
                                            : 25'(25'(y_q) - 25'(mean_q))};
          rem_q   <= '0;
          dvs_q   <= count_q;
        end
        ST_DIV, ST_VDIV: begin
          dvd_q <= {dvd_q[62:0], ~rtry[DW-1]};
          rem_q <= rtry[DW-1] ? rsh[DW-2:0] : rtry[DW-2:0];
          step_q <= step_q + 6'd1;
          if (step_q == 6'd63) st_q <= (st_q == ST_DIV) ? ST_MUP : ST_SQRT;
          if (step_q == 6'd63 && st_q == ST_VDIV) begin
            sv_q   <= {dvd_q[62:0], ~rtry[DW-1]};
            sr_q   <= '0;
            sbit_q <= 64'd1 << 62;
          end
        end
        ST_MUP: begin
          mean_q <= dneg_q ? 24'(mean_q - $signed(dvd_q[23:0]))
                           : 24'(mean_q + $signed(dvd_q[23:0]));
          st_q   <= ST_PROD;
        end
        ST_PROD: begin
          if (prodw > 0) begin
            m2_q <= (m2_q > ~64'(prodw)) ? '1 : m2_q + 64'(prodw);
          end
          if (count_q > 1) begin
            st_q   <= ST_VDIV;
            step_q <= '0;
            dvd_q  <= (prodw > 0) ? ((m2_q > ~64'(prodw)) ? '1 : m2_q + 64'(prodw)) : m2_q;
            rem_q  <= '0;
            dvs_q  <= count_q - 1'b1;
          end else begin
            st_q <= ST_OUT;
          end
        end
        ST_SQRT: begin
          // One result bit per cycle; leading zero pairs just fall through.
          if (sbit_q != 0) begin
            if (sv_q >= sr_q + sbit_q) begin
              sv_q <= sv_q - (sr_q + sbit_q);
              sr_q <= (sr_q >> 1) + sbit_q;
            end else begin
              sr_q <= sr_q >> 1;
            end
            sbit_q <= sbit_q >> 2;
          end else begin
            emu_q  <= mean_q;
            esig_q <= (sr_q > 64'hFFFFFF) ? 24'hFFFFFF : sr_q[23:0];
            pub_q  <= 1'b1;
            st_q   <= ST_OUT;
          end
        end
        ST_OUT: begin
          res_full_q <= 1'b1;
          st_q       <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    res_o.mu    = emu_q;
    res_o.sigma = esig_q;
    res_o.seen  = 32'(count_q);
    res_o.pub   = pub_q;
  end
endmodule

/* test/tb_log_rtt_running_stats.sv */
module tb_log_rtt_running_stats;
  timeunit 1ns;
  timeprecision 1ps;

  import lrs_pkg::*;

  localparam int unsigned NUM_RANDOM = 1300;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct {
    logic signed [23:0] mu;
    logic [23:0]        sigma;
    logic [31:0]        seen;
    logic               pub;
  } stats_t;

  typedef struct {
    logic [23:0] rtt;
    logic        has_exp;
    stats_t      exp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;  // mu_log, sigma_log, samples_seen
  logic        m_axis_tuser;  // published

  // Predictor state.
  logic [31:0]        n_samples;
  logic signed [63:0] run_mean;
  logic [63:0]        sq_dev_sum;
  logic signed [23:0] shown_mu;
  logic [23:0]        shown_sigma;

  stats_t pending_stats[$];
  row_t   rows[$];
  int     errors = 0;
  int     idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  log_rtt_running_stats i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic logic signed [63:0] ln_seconds(input logic [23:0] t);
    int unsigned msb;
    logic [63:0] mant, sq, lg, prod, mag;
    msb = 0;
    for (int i = 0; i < 24; i++) if (t[i]) msb = i;
    mant = 64'(t) << (31 - msb);
    lg = '0;
    for (int i = 0; i < LOG2_FRAC; i++) begin
      sq = mant * mant;
      lg = lg << 1;
      if (sq[63]) begin
        lg[0] = 1'b1;
        mant = sq >> 32;
      end else begin
        mant = sq >> 31;
      end
    end
    lg = lg | (64'(msb) << LOG2_FRAC);
    prod = lg * 64'(LN2_Q31);
    prod = (prod + (64'd1 << 26)) >> 27;
    mag = 64'(LN1E9_Q32) - prod;
    mag = (mag + (64'd1 << (32 - FRAC_BITS_DEF - 1))) >> (32 - FRAC_BITS_DEF);
    if (mag > (64'd1 << 23)) mag = 64'd1 << 23;
    return -$signed(mag);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic reset_stats();
    n_samples   = '0;
    run_mean    = '0;
    sq_dev_sum  = '0;
    shown_mu    = -(24'sd4 <<< FRAC_BITS_DEF);
    shown_sigma = 24'd1 << (FRAC_BITS_DEF - 1);
  endtask

  function automatic stats_t fold_sample(input logic [23:0] t);
    logic signed [63:0] y, d1, d2, p;
    logic [63:0] var_q, sd;
    stats_t r;
    r.pub = 1'b0;
    if (t != 0) begin
      y = ln_seconds(t);
      if (n_samples < COUNT_MAX) n_samples = n_samples + 1;
      d1 = y - run_mean;
      run_mean = run_mean + d1 / $signed({32'd0, n_samples});
      d2 = y - run_mean;
      p = d1 * d2;
      if (p > 0) begin
        if (sq_dev_sum > ~64'd0 - 64'(p)) sq_dev_sum = ~64'd0;
        else sq_dev_sum = sq_dev_sum + 64'(p);
      end
      if (n_samples > 1) begin
        var_q = sq_dev_sum / (64'(n_samples) - 1);
        sd = int_sqrt(var_q);
        shown_mu = run_mean[23:0];
        shown_sigma = (sd > 64'hFF_FFFF) ? 24'hFF_FFFF : sd[23:0];
        r.pub = 1'b1;
      end
    end
    r.mu = shown_mu;
    r.sigma = shown_sigma;
    r.seen = n_samples;
    return r;
  endfunction

  // Sender: bursts of random length with random gaps.
  task automatic send_rtt(input logic [23:0] t);
    s_axis_tdata  <= t;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic gap_maybe(inout int burst);
    int g;
    if (burst > 0) begin
      burst--;
      return;
    end
    burst = $urandom_range(0, 12);
    g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic [23:0] random_rtt();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 24'($urandom_range(1, 255));
      2:       return 24'hFF_FFFF - 24'($urandom_range(0, 15));
      3:       return 24'd1 << $urandom_range(0, 23);
      default: return 24'($urandom_range(1_000_000, 3_000_000));
    endcase
  endfunction

  // Accepted inputs feed the predictor at the clock edge.
  always @(posedge clk_i) begin
    row_t r;
    stats_t s;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      r = rows.pop_front();
      s = fold_sample(s_axis_tdata);
      if (r.has_exp) s = r.exp;
      pending_stats.push_back(s);
    end
  end

  always @(posedge clk_i) begin
    stats_t e;
    logic signed [23:0] got_mu;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_mu = m_axis_tdata[23:0];
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected item mu=%0d sigma=%0d seen=%0d pub=%0b", $time,
                 got_mu, m_axis_tdata[47:24], m_axis_tdata[79:48], m_axis_tuser);
        errors++;
      end else begin
        e = pending_stats.pop_front();
        if (got_mu !== e.mu) begin
          $display("%0t: mu expected %0d actual %0d", $time, e.mu, got_mu);
          errors++;
        end
        if (m_axis_tdata[47:24] !== e.sigma) begin
          $display("%0t: sigma expected %0d actual %0d", $time, e.sigma,
                   m_axis_tdata[47:24]);
          errors++;
        end
        if (m_axis_tdata[79:48] !== e.seen) begin
          $display("%0t: seen expected %0d actual %0d", $time, e.seen,
                   m_axis_tdata[79:48]);
          errors++;
        end
        if (m_axis_tuser !== e.pub) begin
          $display("%0t: published expected %0b actual %0b", $time, e.pub,
                   m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Receiver stalls are random, drawn anew at each clock edge.
  always @(posedge clk_i) begin
    int unsigned phase;
    phase = $urandom_range(0, 63);
    if (phase < 16) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic row_t mk_row(input logic [23:0] t);
    row_t r;
    r.rtt = t;
    r.has_exp = 1'b0;
    return r;
  endfunction

  initial begin
    row_t table_rows[$];
    row_t r;
    int burst;
    logic [23:0] base;
    reset_stats();
    burst = 0;

    // Zero sample straight after reset returns the reset values.
    r = mk_row(24'd0);
    r.has_exp = 1'b1;
    r.exp.mu = -(24'sd4 <<< FRAC_BITS_DEF);
    r.exp.sigma = 24'd1 << (FRAC_BITS_DEF - 1);
    r.exp.seen = 32'd0;
    r.exp.pub = 1'b0;
    table_rows.push_back(r);
    table_rows.push_back(mk_row(24'd1));        // first sample, nothing published
    table_rows.push_back(mk_row(24'd0));
    table_rows.push_back(mk_row(24'hFF_FFFF));
    table_rows.push_back(mk_row(24'd1));
    table_rows.push_back(mk_row(24'hFF_FFFF));
    table_rows.push_back(mk_row(24'd2));
    table_rows.push_back(mk_row(24'h80_0000));
    table_rows.push_back(mk_row(24'h55_5555));
    table_rows.push_back(mk_row(24'hAA_AAAA));
    table_rows.push_back(mk_row(24'd1_000_000));
    table_rows.push_back(mk_row(24'd1_000_000));
    table_rows.push_back(mk_row(24'd0));
    table_rows.push_back(mk_row(24'd3));
    table_rows.push_back(mk_row(24'd7_777_777));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i]) begin
      rows.push_back(table_rows[i]);
      send_rtt(table_rows[i].rtt);
      gap_maybe(burst);
    end

    // Mostly realistic latencies around a drifting base, with outliers.
    base = 24'd1_500_000;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      logic [23:0] t;
      if ($urandom_range(0, 3) == 0) t = random_rtt();
      else t = base + 24'($urandom_range(0, 200_000));
      if ($urandom_range(0, 99) == 0) base = 24'($urandom_range(10_000, 8_000_000));
      rows.push_back(mk_row(t));
      send_rtt(t);
      gap_maybe(burst);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* filelist.f */
sv/lrs_pkg.sv
sv/lrs_front.sv
sv/lrs_back.sv
sv/log_rtt_running_stats.sv
test/tb_log_rtt_running_stats.sv
